### design/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants for the coin credit controller: word formats,
// controller states, the command bundle and the bonus modulo table.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int NUM_MECHS = 3;
  localparam int MECH_W    = 2;

  localparam logic [MECH_W-1:0] MECH_CENTRE = MECH_W'(1);
  localparam logic [MECH_W-1:0] MECH_RIGHT  = MECH_W'(2);

  localparam logic [7:0] STATUS_IDLE   = 8'h1F;
  localparam logic [7:0] STATUS_FAST   = 8'h1B;
  localparam logic [7:0] ABSENT_STEP   = 8'h20;
  localparam logic [7:0] PRE_SLAM_LOAD = 8'hF0;
  localparam logic [7:0] POST_LOAD     = 8'h78;
  localparam logic [7:0] METER_UNIT    = 8'h10;
  localparam logic [7:0] METER_STEP    = 8'hEF;

  localparam logic [2:0] TICK_LAST    = 3'd7;
  localparam logic [2:0] BONUS_DOUBLE = 3'd3;
  localparam logic [1:0] PRICING_FREE = 2'd0;
  localparam logic [1:0] PRICING_ONE  = 2'd2;

  localparam logic [7:0] MODULO_TABLE [8] = '{
    8'h7F, 8'h02, 8'h04, 8'h04, 8'h05, 8'h03, 8'h7F, 8'h7F
  };

  typedef struct packed {
    logic [2:0] coin_switches;
    logic       slam_switch;
  } in_word_t;

  typedef struct packed {
    logic [1:0] credits_added;
    logic [2:0] meter_drive;
    logic       meter_started;
    logic [1:0] meter_index;
    logic       slam_tone;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MECH,
    ST_BONUS,
    ST_CONVERT,
    ST_METER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              mech_step;
    logic [MECH_W-1:0] mech_idx;
    logic              bonus_step;
    logic              convert_step;
    logic              meter_step;
    logic              load_out;
  } cmd_t;

endpackage

### design/coin_credit_controller_unit.sv
// ----------------------------------------------------------------------------
// coin_credit_controller_unit
// Coin mech debounce and coin-to-credit logic, one word per periodic tick.
// ----------------------------------------------------------------------------
// Each tick word runs through these steps from acceptance to a result in the
// output register: one to take the word, one per coin mech as the sequencer
// walks them right to left through a shared debounce unit, then one each for
// the bonus adder, the credit conversion, the meter update and the result
// hand-off. The next word is taken while a result still waits to be read; a
// word only stalls at hand-off if the previous result has not been taken.
// coin_mode may be written at any time the block is idle and takes effect on
// the next word.
module coin_credit_controller_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [7:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccc_pkg::out_word_t out_data
);
  import ccc_pkg::*;

  cmd_t cmd;

  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ccc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_data        (in_data),
    .out_data       (out_data)
  );

  a_credit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.credits_added != 2'd3)
    else $error("credit count out of range");

  a_index_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.meter_started |-> out_data.meter_index == 2'd0)
    else $error("meter index set without a meter start");

endmodule

### design/ccc_ctrl.sv
// ----------------------------------------------------------------------------
// ccc_ctrl
// Sequencer: takes a word, walks the mechs right to left, then runs the
// bonus, conversion and meter steps and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module ccc_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output ccc_pkg::cmd_t cmd
);
  import ccc_pkg::*;

  state_t              state, state_next;
  logic [MECH_W-1:0]   mech, mech_next;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mech      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mech      <= mech_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    mech_next  = mech;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mech_idx = mech;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          mech_next  = MECH_W'(NUM_MECHS - 1);
          state_next = ST_MECH;
        end
      end
      ST_MECH: begin
        cmd.mech_step = 1'b1;
        if (mech == '0) begin
          state_next = ST_BONUS;
        end else begin
          mech_next = mech - MECH_W'(1);
        end
      end
      ST_BONUS: begin
        cmd.bonus_step = 1'b1;
        state_next     = ST_CONVERT;
      end
      ST_CONVERT: begin
        cmd.convert_step = 1'b1;
        state_next       = ST_METER;
      end
      ST_METER: begin
        cmd.meter_step = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_starts_right: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_MECH && mech == MECH_W'(NUM_MECHS - 1))
    else $error("walk does not start at the right mech");

  a_meter_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.meter_step |=> state == ST_DONE)
    else $error("meter step not followed by result hand-off");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.mech_step, cmd.bonus_step, cmd.convert_step,
              cmd.meter_step, cmd.load_out}))
    else $error("more than one datapath step at once");

endmodule

### design/ccc_dp.sv
// ----------------------------------------------------------------------------
// ccc_dp
// Datapath: coin mode register, per-mech debounce, slam timers, unit and
// bonus counters, credit conversion, meter timers and the result register.
// ----------------------------------------------------------------------------
module ccc_dp (
  input  logic               clk,
  input  logic               rst,
  input  ccc_pkg::cmd_t      cmd,
  input  logic               cfg_write_en,
  input  logic [7:0]         cfg_write_data,
  input  ccc_pkg::in_word_t  in_data,
  output ccc_pkg::out_word_t out_data
);
  import ccc_pkg::*;

  logic [7:0] coin_mode;
  logic [2:0] tick_count;
  logic [2:0] sw;
  logic       slam;
  logic [7:0] coin_status     [NUM_MECHS];
  logic [7:0] post_slam_timer [NUM_MECHS];
  logic [7:0] meter_timer     [NUM_MECHS];
  logic [7:0] pre_slam_timer;
  logic [7:0] bonus_unit_count;
  logic [7:0] unit_coin_count;
  logic [7:0] bonus_coins;
  logic [1:0] credits;
  logic       started;
  logic [MECH_W-1:0] which;

  // mech visit
  logic [7:0] st_n, post_n, pre_n, units_add;
  logic       coin;

  always_comb begin
    logic [7:0] status, ptmr;
    logic [4:0] low;
    logic [8:0] sum;
    logic       finish;
    status = coin_status[cmd.mech_idx];
    ptmr   = post_slam_timer[cmd.mech_idx];
    low    = status[4:0];
    sum    = {1'b0, status} + {1'b0, ABSENT_STEP};
    st_n   = status;
    post_n = ptmr;
    pre_n  = pre_slam_timer;
    coin   = 1'b0;
    finish = 1'b0;
    if (sw[cmd.mech_idx]) begin
      if (low != '0 && ({3'b000, low} >= STATUS_FAST || tick_count == TICK_LAST)) begin
        st_n = {3'b000, low - 5'd1};
      end else begin
        st_n = {3'b000, low};
      end
    end else if ({3'b000, low} >= STATUS_FAST) begin
      st_n = STATUS_IDLE;
    end else if (!sum[8]) begin
      st_n = sum[7:0];
    end else if (sum[7:0] == 8'h00) begin
      st_n = STATUS_IDLE;
    end else begin
      coin   = (ptmr != 8'h00);
      st_n   = STATUS_IDLE;
      post_n = POST_LOAD;
      finish = 1'b1;
    end
    if (!finish) begin
      if (slam) begin
        pre_n = PRE_SLAM_LOAD;
      end
      if (pre_n != 8'h00) begin
        pre_n  = pre_n - 8'd1;
        st_n   = 8'h00;
        post_n = 8'h00;
      end
      if (post_n != 8'h00) begin
        post_n = post_n - 8'd1;
        coin   = (post_n == 8'h00);
      end
    end
  end

  // units per coin for the visited mech
  always_comb begin
    logic [7:0] extra;
    extra = 8'h00;
    if (cmd.mech_idx == MECH_RIGHT) begin
      extra = {6'b0, coin_mode[3:2]};
      if (extra != 8'h00) begin
        extra = extra + 8'd2;
      end
    end else if (cmd.mech_idx == MECH_CENTRE) begin
      extra = {7'b0, coin_mode[4]};
    end
    units_add = extra + 8'd1;
  end

  // bonus adder
  logic [2:0] bonus_sel;
  logic [7:0] bonus_rem;

  assign bonus_sel = coin_mode[7:5];
  assign bonus_rem = bonus_unit_count - MODULO_TABLE[bonus_sel];

  // credit conversion
  logic [7:0] unit_n, bc_n;
  logic [1:0] credits_n;

  always_comb begin
    logic [1:0] pricing;
    logic [7:0] price, t;
    pricing   = coin_mode[1:0];
    price     = {7'b0, pricing[1]} + {7'b0, pricing[0]};
    t         = unit_coin_count - price + bonus_coins;
    unit_n    = unit_coin_count;
    bc_n      = bonus_coins;
    credits_n = 2'd0;
    if (pricing == PRICING_FREE) begin
      unit_n = 8'h00;
    end else if (unit_coin_count >= price) begin
      unit_n    = unit_coin_count - price;
      credits_n = (pricing < PRICING_ONE) ? 2'd2 : 2'd1;
    end else if (!t[7]) begin
      bc_n      = t;
      unit_n    = 8'h00;
      credits_n = (pricing < PRICING_ONE) ? 2'd2 : 2'd1;
    end
  end

  // meter pulses
  logic [7:0]        mt_n [NUM_MECHS];
  logic              started_n;
  logic [MECH_W-1:0] which_n;

  always_comb begin
    logic running, found;
    running   = 1'b0;
    found     = 1'b0;
    started_n = 1'b0;
    which_n   = '0;
    for (int m = NUM_MECHS - 1; m >= 0; m--) begin
      mt_n[m] = meter_timer[m];
      if (meter_timer[m] >= METER_UNIT) begin
        mt_n[m] = meter_timer[m] - METER_UNIT;
        running = 1'b1;
      end
    end
    if (!running) begin
      for (int m = NUM_MECHS - 1; m >= 0; m--) begin
        if (!found && meter_timer[m] != 8'h00) begin
          mt_n[m] = meter_timer[m] + METER_STEP;
          if (mt_n[m][7]) begin
            found     = 1'b1;
            started_n = 1'b1;
            which_n   = MECH_W'(m);
          end
        end
      end
    end
  end

  logic [2:0] drive;

  always_comb begin
    drive = '0;
    for (int m = 0; m < NUM_MECHS; m++) begin
      drive[m] = meter_timer[m][7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_mode        <= 8'h00;
      tick_count       <= 3'd0;
      pre_slam_timer   <= 8'h00;
      bonus_unit_count <= 8'h00;
      unit_coin_count  <= 8'h00;
      bonus_coins      <= 8'h00;
      for (int m = 0; m < NUM_MECHS; m++) begin
        coin_status[m]     <= 8'h00;
        post_slam_timer[m] <= 8'h00;
        meter_timer[m]     <= 8'h00;
      end
    end else begin
      if (cfg_write_en) begin
        coin_mode <= cfg_write_data;
      end
      if (cmd.accept) begin
        tick_count <= tick_count + 3'd1;
      end
      if (cmd.mech_step) begin
        coin_status[cmd.mech_idx]     <= st_n;
        post_slam_timer[cmd.mech_idx] <= post_n;
        pre_slam_timer                <= pre_n;
        if (coin) begin
          bonus_unit_count        <= bonus_unit_count + units_add;
          unit_coin_count         <= unit_coin_count + units_add;
          meter_timer[cmd.mech_idx] <= meter_timer[cmd.mech_idx] + 8'd1;
        end
      end
      if (cmd.bonus_step && !bonus_rem[7]) begin
        bonus_unit_count <= bonus_rem;
        bonus_coins      <= bonus_coins + ((bonus_sel == BONUS_DOUBLE) ? 8'd2 : 8'd1);
      end
      if (cmd.convert_step) begin
        unit_coin_count <= unit_n;
        bonus_coins     <= bc_n;
      end
      if (cmd.meter_step && !tick_count[0]) begin
        for (int m = 0; m < NUM_MECHS; m++) begin
          meter_timer[m] <= mt_n[m];
        end
      end
    end
  end

  // result word, payload only
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sw   <= in_data.coin_switches;
      slam <= in_data.slam_switch;
    end
    if (cmd.convert_step) begin
      credits <= credits_n;
    end
    if (cmd.meter_step) begin
      started <= started_n && !tick_count[0];
      which   <= (started_n && !tick_count[0]) ? which_n : '0;
    end
    if (cmd.load_out) begin
      out_data.credits_added <= credits;
      out_data.meter_drive   <= drive;
      out_data.meter_started <= started;
      out_data.meter_index   <= which;
      out_data.slam_tone     <= (pre_slam_timer != 8'h00);
    end
  end

endmodule
